// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

   // Widths of the item fields on the ports.
   localparam int INDEX_BITS = 10;
   localparam int DATA_BITS  = 32;

   // Search bounds carry two extra bits: low can step past the last index
   // and high can step below zero.
   localparam int BOUND_W = INDEX_BITS + 2;

   // The index wrap splits an index into two halves of this many low bits.
   localparam int SPLIT_BITS = INDEX_BITS / 2;

   // Item commands.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // capture the request item; a write also updates the table
      logic probe;      // latch the midpoint and read the table there
      logic step;       // narrow the bounds or record a hit
      logic load_rsp;   // move the finished result into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_empty;
      logic key_hit;
      logic rsp_free;
   } ctl_status_type;

endpackage

// ===== rtl/stbs_ctrl.sv =====
module stbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   input  stbs_pkg::ctl_status_type status,
   output stbs_pkg::ctl_cmd_type    cmd,
   output logic                    req_stall
);
   import stbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_SEARCH) ? ST_CHECK : ST_DONE;
            end
         end
         ST_CHECK: begin
            state_in = status.range_empty ? ST_DONE : ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = status.key_hit ? ST_DONE : ST_CHECK;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_CHECK: begin
            cmd.probe = !status.range_empty;
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/stbs_dp.sv =====
module stbs_dp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int WORD_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stbs_pkg::ctl_cmd_type               cmd,
   output stbs_pkg::ctl_status_type            status,
   input  logic                                req_cmd,
   input  logic [stbs_pkg::INDEX_BITS-1:0]     req_entry_index,
   input  logic signed [stbs_pkg::DATA_BITS-1:0] req_data_word,
   input  logic [stbs_pkg::INDEX_BITS-1:0]     req_range_low,
   input  logic [stbs_pkg::INDEX_BITS-1:0]     req_range_high,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic                                rsp_was_search
);
   import stbs_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int EXT_W    = (WORD_WIDTH > DATA_BITS) ? WORD_WIDTH : DATA_BITS;
   localparam int LO_COUNT = 1 << SPLIT_BITS;
   localparam int HI_COUNT = 1 << (INDEX_BITS - SPLIT_BITS);
   localparam logic [WORD_WIDTH-1:0] SIGN_MASK = WORD_WIDTH'(1) << (WORD_WIDTH - 1);

   // Table entries and the key are held with the sign bit flipped, so an
   // unsigned compare gives the signed order.
   logic [WORD_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [WORD_WIDTH-1:0] rdata_ff;
   logic [WORD_WIDTH-1:0] key_ff;
   logic [WORD_WIDTH-1:0] word_biased;
   logic [EXT_W-1:0]      data_ext;

   logic signed [BOUND_W-1:0] low_ff, low_in;
   logic signed [BOUND_W-1:0] high_ff, high_in;
   logic signed [BOUND_W-1:0] mid_sum;
   logic signed [BOUND_W-1:0] mid_ext;
   logic [INDEX_BITS-1:0]     mid_comb;
   logic [INDEX_BITS-1:0]     mid_ff;
   logic                      was_search_ff;
   logic                      hit_ff;
   logic                      key_below;
   logic                      key_equal;

   logic [INDEX_BITS-1:0] wrap_src;
   logic [IDX_W-1:0]      lo_rem [LO_COUNT];
   logic [IDX_W-1:0]      hi_rem [HI_COUNT];
   logic [IDX_W:0]        wrap_sum;
   logic [IDX_W-1:0]      mem_addr;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff;
   logic rsp_was_search_ff;

   assign data_ext    = EXT_W'($unsigned(req_data_word));
   assign word_biased = data_ext[WORD_WIDTH-1:0] ^ SIGN_MASK;

   // Index wrap modulo the table depth: each half of the index looks up its
   // own remainder, and the sum of two remainders needs one correction.
   for (genvar g = 0; g < LO_COUNT; g++) begin : g_lo_rem
      localparam int unsigned LoRem = g % TABLE_DEPTH;
      assign lo_rem[g] = IDX_W'(LoRem);
   end
   for (genvar g = 0; g < HI_COUNT; g++) begin : g_hi_rem
      localparam int unsigned HiRem = (g * LO_COUNT) % TABLE_DEPTH;
      assign hi_rem[g] = IDX_W'(HiRem);
   end

   assign mid_sum  = low_ff + high_ff;
   assign mid_comb = mid_sum[INDEX_BITS:1];
   assign wrap_src = cmd.accept ? req_entry_index : mid_comb;
   assign wrap_sum = {1'b0, hi_rem[wrap_src[INDEX_BITS-1:SPLIT_BITS]]}
                   + {1'b0, lo_rem[wrap_src[SPLIT_BITS-1:0]]};

   always_comb begin
      if (wrap_sum >= (IDX_W + 1)'(TABLE_DEPTH)) begin
         mem_addr = IDX_W'(wrap_sum - (IDX_W + 1)'(TABLE_DEPTH));
      end else begin
         mem_addr = wrap_sum[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_cmd == CMD_WRITE)) begin
         mem[mem_addr] <= word_biased;
      end
      if (cmd.probe) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign key_below = key_ff < rdata_ff;
   assign key_equal = key_ff == rdata_ff;
   assign mid_ext   = signed'(BOUND_W'(mid_ff));

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.accept) begin
         low_in  = signed'(BOUND_W'(req_range_low));
         high_in = signed'(BOUND_W'(req_range_high));
      end else if (cmd.step && !key_equal) begin
         if (key_below) begin
            high_in = mid_ext - BOUND_W'(1);
         end else begin
            low_in = mid_ext + BOUND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      if (cmd.accept) begin
         key_ff        <= word_biased;
         was_search_ff <= (req_cmd == CMD_SEARCH);
         hit_ff        <= 1'b0;
      end else if (cmd.step && key_equal) begin
         hit_ff <= 1'b1;
      end
      if (cmd.probe) begin
         mid_ff <= mid_comb;
      end
   end

   // Output register: it holds a finished result while the next item runs.
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found_ff      <= hit_ff & was_search_ff;
         rsp_was_search_ff <= was_search_ff;
      end
   end

   assign status.range_empty = low_ff > high_ff;
   assign status.key_hit     = key_equal;
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_was_search = rsp_was_search_ff;

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Channel   | Ports                                                    | Direction
// ----------+----------------------------------------------------------+----------
// request   | req_valid, req_stall, req_cmd, req_entry_index,          | in
//           | req_data_word, req_range_low, req_range_high             |
// response  | rsp_valid, rsp_stall, rsp_found, rsp_was_search          | out
//
// A write item goes from the idle state straight to the done state. A search item
// alternates a check state, which registers the table read at the midpoint, with a
// compare state that narrows the bounds; a hit or an empty range ends it in the done
// state, and it makes at most 11 probes for a 1024-entry table. Reset clears only the
// controller and the response valid; table contents are unknown until written. A stalled
// response stays in the output register while the next item runs; if it is still stalled
// when that item finishes, the block waits with its input stalled.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int WORD_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [stbs_pkg::INDEX_BITS-1:0]       req_entry_index,
   input  logic signed [stbs_pkg::DATA_BITS-1:0] req_data_word,
   input  logic [stbs_pkg::INDEX_BITS-1:0]       req_range_low,
   input  logic [stbs_pkg::INDEX_BITS-1:0]       req_range_high,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic                                  rsp_was_search
);
   import stbs_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // The controller walks each item through accept, probe, compare and
   // result hand-off; it takes a new item only from its idle state.
   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // The datapath holds the table memory, the search bounds, the key, the
   // index wrap and the response register.
   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_data_word   (req_data_word),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_was_search  (rsp_was_search)
   );

endmodule

// ===== rtl/stbs_checker.sv =====
module stbs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_cmd,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_found,
   input logic rsp_was_search
);
   import stbs_pkg::*;

   logic       req_take;
   logic       rsp_take;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Items accepted whose result has not yet been taken.
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("second item accepted while one is in flight");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0) && (pending_ff != 2'd3))
      else $error("response without a matching item");

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_search |-> !rsp_found)
      else $error("write acknowledge reports found");

   a_write_time: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_cmd == CMD_WRITE) && !rsp_valid
      |-> ##2 (rsp_valid && !rsp_was_search))
      else $error("write acknowledge late");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_found      (rsp_found),
   .rsp_was_search (rsp_was_search)
);
